FILE: hw/rtl/clcd_pkg.sv
// clcd_pkg: shared types, codes and constant tables for the character LCD
// nibble write sequencer. No dependencies.
package clcd_pkg;

  // Request codes on in_cmd
  localparam logic [2:0] CMD_CHAR    = 3'd0;
  localparam logic [2:0] CMD_COMMAND = 3'd1;
  localparam logic [2:0] CMD_CURSOR  = 3'd2;
  localparam logic [2:0] CMD_NUMBER  = 3'd3;
  localparam logic [2:0] CMD_POWERUP = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_FUNCTION_SET    = 2'd0;
  localparam logic [1:0] REG_DISPLAY_CONTROL = 2'd1;
  localparam logic [1:0] REG_ENTRY_MODE      = 2'd2;

  localparam logic [7:0] FUNCTION_SET_RST    = 8'h28;
  localparam logic [7:0] DISPLAY_CONTROL_RST = 8'h0C;
  localparam logic [7:0] ENTRY_MODE_RST      = 8'h06;

  localparam logic [7:0] CLEAR_DISPLAY_BYTE = 8'h01;
  localparam logic [7:0] RETURN_HOME_BYTE   = 8'h02;

  // Wait codes on out_wait_after
  localparam logic [1:0] WAIT_NONE     = 2'd0;
  localparam logic [1:0] WAIT_ONE_CMD  = 2'd1;
  localparam logic [1:0] WAIT_TWO_CMD  = 2'd2;
  localparam logic [1:0] WAIT_POWER_ON = 2'd3;

  localparam logic [2:0] MAX_DIGITS      = 3'd5;
  localparam logic [3:0] POWERUP_LAST    = 4'd13;
  localparam logic [3:0] POWERUP_NIB_END = 4'd4;

  typedef enum logic [1:0] {
    K_BYTE    = 2'd0,
    K_NUMBER  = 2'd1,
    K_POWERUP = 2'd2
  } kind_t;

  // One queued job for the back end
  typedef struct packed {
    kind_t           kind;
    logic            rs;
    logic [7:0]      data_val;
    logic [4:0][3:0] digits;     // decimal digit by position
    logic [2:0]      first_pos;  // position of the first digit sent
    logic [3:0]      last_step;  // index of the final pulse
  } desc_t;

  typedef struct packed {
    logic [7:0] function_set;
    logic [7:0] display_control;
    logic [7:0] entry_mode;
  } cfg_t;

  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    case (row)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'hC0;
      2'd2:    b = 8'h94;
      default: b = 8'hD4;
    endcase
    return b;
  endfunction

  function automatic logic [16:0] dec_weight(input logic [2:0] pos);
    logic [16:0] w;
    case (pos)
      3'd0:    w = 17'd1;
      3'd1:    w = 17'd10;
      3'd2:    w = 17'd100;
      3'd3:    w = 17'd1000;
      default: w = 17'd10000;
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/clcd_front.sv
// clcd_front: accepts requests, classifies them and builds queue entries.
// Number requests go through a digit-per-cycle decimal converter. Uses clcd_pkg.
module clcd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_cmd,
  input  logic [7:0]         in_data_byte,
  input  logic [5:0]         in_column,
  input  logic [1:0]         in_row_index,
  input  logic [15:0]        in_number_value,
  input  logic [2:0]         in_pad_digits,
  input  logic               q_full,
  output logic               q_push,
  output clcd_pkg::desc_t    q_desc
);
  import clcd_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t         state_r, state_nxt;
  logic [15:0]     rem_r;
  logic [2:0]      pos_r;
  logic [2:0]      pad_r;
  logic [4:0][3:0] dig_r;

  logic        acc;
  logic        imm_push;
  logic        start_cvt;
  logic [2:0]  pad_c;
  desc_t       imm_desc;
  desc_t       num_desc;
  logic [3:0]  dig_d;
  logic [16:0] sub_v;

  assign in_stall = (state_r != F_IDLE) || q_full;
  assign acc      = in_valid && !in_stall;
  assign pad_c    = (in_pad_digits > MAX_DIGITS) ? MAX_DIGITS : in_pad_digits;

  // classify the incoming word
  always_comb begin
    imm_desc           = '0;
    imm_desc.kind      = K_BYTE;
    imm_desc.last_step = 4'd1;
    imm_push           = 1'b0;
    start_cvt          = 1'b0;
    case (in_cmd)
      CMD_CHAR: begin
        imm_desc.rs       = 1'b1;
        imm_desc.data_val = in_data_byte;
        imm_push          = 1'b1;
      end
      CMD_COMMAND: begin
        imm_desc.data_val = in_data_byte;
        imm_push          = 1'b1;
      end
      CMD_CURSOR: begin
        imm_desc.data_val = row_base(in_row_index) + {2'b00, in_column};
        imm_push          = 1'b1;
      end
      CMD_NUMBER: begin
        start_cvt = (pad_c != 3'd0);
      end
      CMD_POWERUP: begin
        imm_desc.kind      = K_POWERUP;
        imm_desc.last_step = POWERUP_LAST;
        imm_push           = 1'b1;
      end
      default: begin
        imm_push = 1'b0;  // unknown request, dropped
      end
    endcase
  end

  // one decimal digit per cycle: largest multiple of the weight that fits
  always_comb begin
    logic [16:0] cand;
    dig_d = 4'd0;
    sub_v = '0;
    for (int m = 1; m <= 9; m++) begin
      cand = 17'(m) * dec_weight(pos_r);
      if ({1'b0, rem_r} >= cand) begin
        dig_d = 4'(m);
        sub_v = cand;
      end
    end
  end

  always_comb begin
    num_desc           = '0;
    num_desc.kind      = K_NUMBER;
    num_desc.rs        = 1'b1;
    num_desc.digits    = dig_r;
    num_desc.first_pos = pad_r - 3'd1;
    num_desc.last_step = 4'({pad_r, 1'b0}) - 4'd1;
  end

  assign q_push = ((state_r == F_PUSH) && !q_full) || (acc && imm_push);
  assign q_desc = (state_r == F_PUSH) ? num_desc : imm_desc;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: if (acc && start_cvt) state_nxt = F_CONV;
      F_CONV: if (pos_r == 3'd0) state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && acc && start_cvt) begin
      rem_r <= in_number_value;
      pos_r <= 3'd4;
      pad_r <= pad_c;
    end else if (state_r == F_CONV) begin
      dig_r[pos_r] <= dig_d;
      rem_r        <= 16'({1'b0, rem_r} - sub_v);
      pos_r        <= pos_r - 3'd1;
    end
  end

endmodule

FILE: hw/rtl/clcd_queue.sv
// clcd_queue: small register FIFO of job entries between front and back.
// Uses clcd_pkg.
module clcd_queue #(
  parameter int DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  clcd_pkg::desc_t push_desc,
  input  logic            pop,
  output clcd_pkg::desc_t head,
  output logic            full,
  output logic            empty
);
  import clcd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_desc;
  end

endmodule

FILE: hw/rtl/clcd_back.sv
// clcd_back: walks each queued job and emits one enable-pulse word per cycle
// into an output register unless out_stall holds it. Uses clcd_pkg.
module clcd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  clcd_pkg::cfg_t  cfg,
  input  clcd_pkg::desc_t q_head,
  input  logic            q_empty,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic            out_reg_select,
  output logic [3:0]      out_nibble,
  output logic            out_wait_before,
  output logic [1:0]      out_wait_after,
  output logic            out_last_of_run
);
  import clcd_pkg::*;

  logic       busy_r;
  desc_t      desc_r;
  logic [3:0] step_r;
  logic       out_valid_r;
  logic       rs_r, wb_r, last_r;
  logic [3:0] nib_r;
  logic [1:0] wa_r;

  desc_t      src;
  logic [3:0] step;
  logic       out_free, advance;
  logic       rs_d, wb_d, last_d;
  logic [3:0] nib_d;
  logic [1:0] wa_d;
  logic [7:0] byte_sel;
  logic [2:0] pos;
  logic [2:0] pidx;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = out_free && (busy_r || !q_empty);
  assign q_pop    = advance && !busy_r;
  assign src      = busy_r ? desc_r : q_head;
  assign step     = busy_r ? step_r : 4'd0;
  assign pos      = src.first_pos - 3'(step[3:1]);
  assign pidx     = 3'((step - POWERUP_NIB_END) >> 1);

  always_comb begin
    rs_d     = src.rs;
    wb_d     = 1'b0;
    byte_sel = src.data_val;
    case (src.kind)
      K_BYTE:   byte_sel = src.data_val;
      K_NUMBER: byte_sel = {4'h3, src.digits[pos]};  // ASCII digit
      K_POWERUP: begin
        rs_d = 1'b0;
        case (pidx)
          3'd0:    byte_sel = cfg.function_set;
          3'd1:    byte_sel = cfg.display_control;
          3'd2:    byte_sel = cfg.entry_mode;
          3'd3:    byte_sel = CLEAR_DISPLAY_BYTE;
          default: byte_sel = RETURN_HOME_BYTE;
        endcase
      end
      default: byte_sel = src.data_val;
    endcase
    // bytes go high nibble first; the low nibble gets one command delay
    nib_d = step[0] ? byte_sel[3:0] : byte_sel[7:4];
    wa_d  = step[0] ? WAIT_ONE_CMD : WAIT_NONE;
    // power-up wake-up nibbles
    if (src.kind == K_POWERUP && step < POWERUP_NIB_END) begin
      nib_d = (step == 4'd3) ? 4'h2 : 4'h3;
      wb_d  = (step == 4'd0);
      case (step)
        4'd0:    wa_d = WAIT_POWER_ON;
        4'd1:    wa_d = WAIT_TWO_CMD;
        default: wa_d = WAIT_ONE_CMD;
      endcase
    end
    last_d = (step == src.last_step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) out_valid_r <= advance;
      if (advance)  busy_r      <= !last_d;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      desc_r <= src;
      step_r <= step + 4'd1;
      rs_r   <= rs_d;
      nib_r  <= nib_d;
      wb_r   <= wb_d;
      wa_r   <= wa_d;
      last_r <= last_d;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reg_select  = rs_r;
  assign out_nibble      = nib_r;
  assign out_wait_before = wb_r;
  assign out_wait_after  = wa_r;
  assign out_last_of_run = last_r;

endmodule

FILE: hw/rtl/char_lcd_nibble_write_sequencer_top.sv
// Character LCD nibble write sequencer, top level. A char, command, cursor or
// power-up word goes straight into the queue; a number word first passes the
// decimal converter, and the front takes no new request until it is pushed.
// The output gives one pulse word per cycle while out_stall is low. Reset
// (rst_n low, synchronous) empties the queue and output register and restores
// the power-up command registers.
module char_lcd_nibble_write_sequencer_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_data_byte,
  input  logic [5:0]  in_column,
  input  logic [1:0]  in_row_index,
  input  logic [15:0] in_number_value,
  input  logic [2:0]  in_pad_digits,
  // pulse channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_reg_select,
  output logic [3:0]  out_nibble,
  output logic        out_wait_before,
  output logic [1:0]  out_wait_after,
  output logic        out_last_of_run
);
  import clcd_pkg::*;

  cfg_t  cfg_r;
  desc_t q_desc, q_head;
  logic  q_push, q_pop, q_full, q_empty;

  // Power-up command bytes; the user must write them only while the sequencer
  // is idle (the block does not enforce this), so the back end reads them live.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.function_set    <= FUNCTION_SET_RST;
      cfg_r.display_control <= DISPLAY_CONTROL_RST;
      cfg_r.entry_mode      <= ENTRY_MODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FUNCTION_SET:    cfg_r.function_set    <= cfg_data;
        REG_DISPLAY_CONTROL: cfg_r.display_control <= cfg_data;
        REG_ENTRY_MODE:      cfg_r.entry_mode      <= cfg_data;
        default:             cfg_r                 <= cfg_r;  // unmapped index
      endcase
    end
  end

  // Front: classify requests, run decimal conversion, drop empty requests
  // (unknown codes, zero-digit numbers).
  clcd_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .in_column       (in_column),
    .in_row_index    (in_row_index),
    .in_number_value (in_number_value),
    .in_pad_digits   (in_pad_digits),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_desc          (q_desc)
  );

  // Job queue decoupling front and back
  clcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // Back: one pulse per cycle while out_stall is low, next job starts with no bubble
  clcd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_head          (q_head),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reg_select  (out_reg_select),
    .out_nibble      (out_nibble),
    .out_wait_before (out_wait_before),
    .out_wait_after  (out_wait_after),
    .out_last_of_run (out_last_of_run)
  );

endmodule

FILE: hw/rtl/clcd_chk.sv
// clcd_chk: port-level checks for the LCD nibble write sequencer, bound to
// the top level. Uses clcd_pkg codes.
module clcd_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_reg_select,
  input logic [3:0] out_nibble,
  input logic       out_wait_before,
  input logic [1:0] out_wait_after,
  input logic       out_last_of_run
);
  import clcd_pkg::*;

  // output register comes up empty
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_nibble) &&
      $stable(out_last_of_run) && $stable(out_wait_after))
    else $error("stalled pulse word changed");

  // only the first wake-up nibble has the long leading wait
  a_wake_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wait_before |-> out_wait_after == WAIT_POWER_ON &&
      !out_reg_select && out_nibble == 4'h3 && !out_last_of_run)
    else $error("bad first wake-up pulse");

  a_power_on_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wait_after == WAIT_POWER_ON |-> out_wait_before)
    else $error("power-on wait without leading wait");

  // a high nibble never ends a run
  a_high_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wait_after == WAIT_NONE |-> !out_last_of_run)
    else $error("run ended on a high nibble");

endmodule

bind char_lcd_nibble_write_sequencer_top clcd_chk u_clcd_chk (.*);

FILE: dv/char_lcd_nibble_write_sequencer_top_tb.sv
// Self-checking bench for char_lcd_nibble_write_sequencer_top: directed table plus random
// requests over several command-byte settings, each pulse word compared to a local predictor.
// Depends on clcd_pkg and the RTL top only.
`timescale 1ns / 1ps

module char_lcd_nibble_write_sequencer_top_tb;
  import clcd_pkg::*;

  // One pulse word as it leaves the block
  typedef struct packed {
    logic       rs;
    logic [3:0] nib;
    logic       wb;
    logic [1:0] wa;
    logic       last;
  } pulse_t;

  // One request word as it enters the block
  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  data;
    logic [5:0]  col;
    logic [1:0]  row;
    logic [15:0] num;
    logic [2:0]  pad;
  } lcd_req_t;

  // Directed row: typed = 1 means p0/p1 (n_typed of them) are the expected pulses,
  // otherwise the predictor works them out.
  typedef struct packed {
    lcd_req_t   req;
    logic       typed;
    logic [1:0] n_typed;
    pulse_t     p0;
    pulse_t     p1;
  } dir_row_t;

  localparam int          DRAIN_CYCLES = 20;   // lets number words through the converter and queue
  localparam int          LONG_HOLD    = 300;  // receiver hold-off, fills the queue
  localparam int          RAND_PHASE   = 80;
  localparam logic [7:0]  ASCII_ZERO   = 8'h30;
  localparam logic [3:0]  WAKE_NIB     = 4'h3; // 8-bit mode wake-up nibble
  localparam logic [3:0]  BUS4_NIB     = 4'h2; // switch to 4-bit bus
  localparam logic [7:0]  ROW_BASE [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};
  localparam pulse_t      NO_PULSE     = '0;

  localparam int DIR_ROWS = 21;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // byte extremes, typed
    '{'{CMD_CHAR, 8'h00, 6'd0, 2'd0, 16'd0, 3'd0}, 1'b1, 2'd2,
      '{1'b1, 4'h0, 1'b0, WAIT_NONE, 1'b0}, '{1'b1, 4'h0, 1'b0, WAIT_ONE_CMD, 1'b1}},
    '{'{CMD_CHAR, 8'hFF, 6'd63, 2'd3, 16'hFFFF, 3'd7}, 1'b1, 2'd2,
      '{1'b1, 4'hF, 1'b0, WAIT_NONE, 1'b0}, '{1'b1, 4'hF, 1'b0, WAIT_ONE_CMD, 1'b1}},
    '{'{CMD_COMMAND, 8'h00, 6'd0, 2'd0, 16'd0, 3'd0}, 1'b1, 2'd2,
      '{1'b0, 4'h0, 1'b0, WAIT_NONE, 1'b0}, '{1'b0, 4'h0, 1'b0, WAIT_ONE_CMD, 1'b1}},
    '{'{CMD_COMMAND, 8'hFF, 6'd63, 2'd3, 16'hFFFF, 3'd7}, 1'b1, 2'd2,
      '{1'b0, 4'hF, 1'b0, WAIT_NONE, 1'b0}, '{1'b0, 4'hF, 1'b0, WAIT_ONE_CMD, 1'b1}},
    '{'{CMD_CHAR, 8'hA5, 6'd17, 2'd1, 16'd4242, 3'd2}, 1'b0, 2'd0, NO_PULSE, NO_PULSE},
    // cursor: row 0 column 0 is 0x80; row 3 column 63 wraps to 0x13
    '{'{CMD_CURSOR, 8'h00, 6'd0, 2'd0, 16'd0, 3'd0}, 1'b1, 2'd2,
      '{1'b0, 4'h8, 1'b0, WAIT_NONE, 1'b0}, '{1'b0, 4'h0, 1'b0, WAIT_ONE_CMD, 1'b1}},
    '{'{CMD_CURSOR, 8'hFF, 6'd63, 2'd3, 16'd0, 3'd0}, 1'b1, 2'd2,
      '{1'b0, 4'h1, 1'b0, WAIT_NONE, 1'b0}, '{1'b0, 4'h3, 1'b0, WAIT_ONE_CMD, 1'b1}},
    '{'{CMD_CURSOR, 8'h3C, 6'd39, 2'd1, 16'd0, 3'd0}, 1'b0, 2'd0, NO_PULSE, NO_PULSE},
    '{'{CMD_CURSOR, 8'h00, 6'd5, 2'd2, 16'd0, 3'd0}, 1'b0, 2'd0, NO_PULSE, NO_PULSE},
    // zero pad: nothing comes out
    '{'{CMD_NUMBER, 8'h00, 6'd0, 2'd0, 16'd1234, 3'd0}, 1'b1, 2'd0, NO_PULSE, NO_PULSE},
    '{'{CMD_NUMBER, 8'h00, 6'd0, 2'd0, 16'hFFFF, 3'd5}, 1'b0, 2'd0, NO_PULSE, NO_PULSE},
    '{'{CMD_NUMBER, 8'h00, 6'd0, 2'd0, 16'd0, 3'd5}, 1'b0, 2'd0, NO_PULSE, NO_PULSE},
    '{'{CMD_NUMBER, 8'h00, 6'd0, 2'd0, 16'd12345, 3'd3}, 1'b0, 2'd0, NO_PULSE, NO_PULSE},
    // oversized pad acts as five digits
    '{'{CMD_NUMBER, 8'h00, 6'd0, 2'd0, 16'hFFFF, 3'd7}, 1'b0, 2'd0, NO_PULSE, NO_PULSE},
    '{'{CMD_NUMBER, 8'h00, 6'd0, 2'd0, 16'd9, 3'd6}, 1'b0, 2'd0, NO_PULSE, NO_PULSE},
    '{'{CMD_NUMBER, 8'h00, 6'd0, 2'd0, 16'd40000, 3'd1}, 1'b0, 2'd0, NO_PULSE, NO_PULSE},
    // undefined request codes are dropped
    '{'{3'd5, 8'h41, 6'd3, 2'd1, 16'd77, 3'd2}, 1'b1, 2'd0, NO_PULSE, NO_PULSE},
    '{'{3'd6, 8'h00, 6'd0, 2'd0, 16'd0, 3'd0}, 1'b1, 2'd0, NO_PULSE, NO_PULSE},
    '{'{3'd7, 8'hFF, 6'd63, 2'd3, 16'hFFFF, 3'd7}, 1'b1, 2'd0, NO_PULSE, NO_PULSE},
    // power-up with reset command bytes
    '{'{CMD_POWERUP, 8'h00, 6'd0, 2'd0, 16'd0, 3'd0}, 1'b0, 2'd0, NO_PULSE, NO_PULSE},
    '{'{CMD_CHAR, 8'h5A, 6'd40, 2'd2, 16'd100, 3'd4}, 1'b0, 2'd0, NO_PULSE, NO_PULSE}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_cmd;
  logic [7:0]  in_data_byte;
  logic [5:0]  in_column;
  logic [1:0]  in_row_index;
  logic [15:0] in_number_value;
  logic [2:0]  in_pad_digits;
  logic        out_valid;
  logic        out_stall;
  logic        out_reg_select;
  logic [3:0]  out_nibble;
  logic        out_wait_before;
  logic [1:0]  out_wait_after;
  logic        out_last_of_run;

  pulse_t pending_pulses [$];   // expected pulse words, oldest first
  cfg_t   lcd_cfg;              // local copy of the command-byte registers
  int     error_count = 0;
  bit     quiet = 1'b0;         // both sides run without idling
  bit     long_hold_req = 1'b0; // asks the receiver for one long hold-off

  char_lcd_nibble_write_sequencer_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_data_byte    (in_data_byte),
    .in_column       (in_column),
    .in_row_index    (in_row_index),
    .in_number_value (in_number_value),
    .in_pad_digits   (in_pad_digits),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reg_select  (out_reg_select),
    .out_nibble      (out_nibble),
    .out_wait_before (out_wait_before),
    .out_wait_after  (out_wait_after),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: turns one request word into its run of enable pulses
  // ---------------------------------------------------------------------------
  function automatic void push_pulse(logic rs, logic [3:0] nib, logic wb, logic [1:0] wa);
    pulse_t p;
    p = '{rs, nib, wb, wa, 1'b0};
    pending_pulses.push_back(p);
  endfunction

  // high nibble first; the low nibble is followed by one command delay
  function automatic void push_byte(logic rs, logic [7:0] b);
    push_pulse(rs, b[7:4], 1'b0, WAIT_NONE);
    push_pulse(rs, b[3:0], 1'b0, WAIT_ONE_CMD);
  endfunction

  function automatic void predict_pulses(lcd_req_t r);
    int          n0;
    int          i;
    int          pad;
    int unsigned v;
    logic [3:0]  digit [5];
    logic [7:0]  addr;
    pulse_t      p;
    n0 = pending_pulses.size();
    case (r.cmd)
      CMD_CHAR:    push_byte(1'b1, r.data);
      CMD_COMMAND: push_byte(1'b0, r.data);
      CMD_CURSOR: begin
        addr = ROW_BASE[r.row] + {2'b00, r.col};  // wraps at 8 bits
        push_byte(1'b0, addr);
      end
      CMD_NUMBER: begin
        pad = (r.pad > MAX_DIGITS) ? int'(MAX_DIGITS) : int'(r.pad);
        v = r.num;
        for (i = 4; i >= 0; i--) begin
          digit[i] = 4'(v % 10);
          v = v / 10;
        end
        // only the low pad digits go out, most significant first
        for (i = 5 - pad; i < 5; i++)
          push_byte(1'b1, ASCII_ZERO | {4'h0, digit[i]});
      end
      CMD_POWERUP: begin
        push_pulse(1'b0, WAKE_NIB, 1'b1, WAIT_POWER_ON);
        push_pulse(1'b0, WAKE_NIB, 1'b0, WAIT_TWO_CMD);
        push_pulse(1'b0, WAKE_NIB, 1'b0, WAIT_ONE_CMD);
        push_pulse(1'b0, BUS4_NIB, 1'b0, WAIT_ONE_CMD);
        push_byte(1'b0, lcd_cfg.function_set);
        push_byte(1'b0, lcd_cfg.display_control);
        push_byte(1'b0, lcd_cfg.entry_mode);
        push_byte(1'b0, CLEAR_DISPLAY_BYTE);
        push_byte(1'b0, RETURN_HOME_BYTE);
      end
      default: ;
    endcase
    // mark the final pulse of this request
    if (pending_pulses.size() > n0) begin
      p = pending_pulses.pop_back();
      p.last = 1'b1;
      pending_pulses.push_back(p);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Valid stays high from one word to the next when no gap is drawn, so it is
  // never dropped and raised in the same step.
  task automatic offer_word(lcd_req_t r);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= r.cmd;
    in_data_byte    <= r.data;
    in_column       <= r.col;
    in_row_index    <= r.row;
    in_number_value <= r.num;
    in_pad_digits   <= r.pad;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Wait out every expected pulse, then the converter latency, so that a
  // word with no pulses (zero pad, bad code) is surely gone too.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_pulses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [7:0] fs, logic [7:0] dc, logic [7:0] em);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FUNCTION_SET;
    cfg_data  <= fs;
    @(posedge clk);
    cfg_index <= REG_DISPLAY_CONTROL;
    cfg_data  <= dc;
    @(posedge clk);
    cfg_index <= REG_ENTRY_MODE;
    cfg_data  <= em;
    @(posedge clk);
    cfg_we <= 1'b0;
    lcd_cfg = '{function_set: fs, display_control: dc, entry_mode: em};
  endtask

  function automatic lcd_req_t random_req();
    lcd_req_t    r;
    int unsigned pick;
    r.data = 8'($urandom);
    r.row  = 2'($urandom);
    // columns past 39 are legal on the port; keep them rare
    r.col  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(40, 63))
                                         : 6'($urandom_range(0, 39));
    r.pad  = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(6, 7))
                                         : 3'($urandom_range(0, 5));
    case ($urandom_range(0, 3))
      0:       r.num = 16'($urandom_range(0, 9));
      1:       r.num = 16'($urandom_range(65530, 65535));
      default: r.num = 16'($urandom);
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 20)      r.cmd = CMD_CHAR;
    else if (pick < 38) r.cmd = CMD_COMMAND;
    else if (pick < 54) r.cmd = CMD_CURSOR;
    else if (pick < 80) r.cmd = CMD_NUMBER;
    else if (pick < 94) r.cmd = CMD_POWERUP;
    else                r.cmd = 3'($urandom_range(5, 7));
    return r;
  endfunction

  // Dropped codes do not count toward the phase length.
  task automatic run_random(int unsigned n_items);
    lcd_req_t    r;
    int unsigned counted;
    counted = 0;
    while (counted < n_items) begin
      quiet = (counted >= 30 && counted < 45);  // a stretch with no idling
      r = random_req();
      offer_word(r);
      predict_pulses(r);
      if (r.cmd <= CMD_POWERUP) counted++;
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall before each pulse word, plus one long
  // hold-off on request so the queue fills and in_stall rises.
  // ---------------------------------------------------------------------------
  initial begin : pulse_sink
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        hold = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 17);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every accepted pulse word against the oldest expectation
  // ---------------------------------------------------------------------------
  function automatic void check_field(string field, logic [3:0] want, logic [3:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin : pulse_check
    pulse_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pulses.size() == 0) begin
        $error("pulse word with nothing expected: nibble %0h", out_nibble);
        error_count++;
      end else begin
        want = pending_pulses.pop_front();
        check_field("reg_select", {3'b0, want.rs}, {3'b0, out_reg_select});
        check_field("nibble", want.nib, out_nibble);
        check_field("wait_before", {3'b0, want.wb}, {3'b0, out_wait_before});
        check_field("wait_after", {2'b0, want.wa}, {2'b0, out_wait_after});
        check_field("last_of_run", {3'b0, want.last}, {3'b0, out_last_of_run});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int i;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_FUNCTION_SET;
    cfg_data        <= 8'h00;
    in_valid        <= 1'b0;
    in_cmd          <= CMD_CHAR;
    in_data_byte    <= 8'h00;
    in_column       <= 6'd0;
    in_row_index    <= 2'd0;
    in_number_value <= 16'd0;
    in_pad_digits   <= 3'd0;
    lcd_cfg = '{function_set: FUNCTION_SET_RST, display_control: DISPLAY_CONTROL_RST,
                entry_mode: ENTRY_MODE_RST};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed table, reset command bytes
    for (i = 0; i < DIR_ROWS; i++) begin
      offer_word(DIRECTED[i].req);
      if (DIRECTED[i].typed) begin
        if (DIRECTED[i].n_typed > 0) pending_pulses.push_back(DIRECTED[i].p0);
        if (DIRECTED[i].n_typed > 1) pending_pulses.push_back(DIRECTED[i].p1);
      end else begin
        predict_pulses(DIRECTED[i].req);
      end
    end
    settle_block();

    // register extremes, a random setting, then back to reset values
    write_cfg(8'h00, 8'h00, 8'h00);
    long_hold_req = 1'b1;
    run_random(RAND_PHASE);
    settle_block();

    write_cfg(8'hFF, 8'hFF, 8'hFF);
    run_random(RAND_PHASE);
    settle_block();

    write_cfg(8'($urandom), 8'($urandom), 8'($urandom));
    long_hold_req = 1'b1;
    run_random(RAND_PHASE);
    settle_block();

    write_cfg(FUNCTION_SET_RST, DISPLAY_CONTROL_RST, ENTRY_MODE_RST);
    run_random(RAND_PHASE);
    settle_block();

    if (error_count == 0) begin
      $display("char_lcd_nibble_write_sequencer_top_tb: clean");
    end else begin
      $display("char_lcd_nibble_write_sequencer_top_tb: errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #6_000_000;
    $display("char_lcd_nibble_write_sequencer_top_tb: errors");
    $finish;
  end

endmodule
